[hw/rtl/rdhc_pkg.sv]
// ----------------------------------------------------------------------------
// rdhc_pkg
// Shared types, constants and the Pearson permutation table for the record
// deframer with hash check.
// ----------------------------------------------------------------------------
package rdhc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 24;
  localparam int unsigned NameLenW = 16;
  localparam int unsigned BodyLenW = 48;
  localparam int unsigned HdrIdxW  = 4;

  localparam logic [ByteW-1:0]   MagicValue  = 8'h42;
  // header bytes after the magic byte: 3 mode, 2 name length, 6 content length
  localparam logic [HdrIdxW-1:0] HeaderBytes = 4'd11;
  localparam logic [HdrIdxW-1:0] ModeEnd     = 4'd3;
  localparam logic [HdrIdxW-1:0] NameLenEnd  = 4'd5;

  // parser phase
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_NAME    = 3'd2,
    PH_CONTENT = 3'd3,
    PH_HASH    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  // role tag carried with every byte
  typedef enum logic [2:0] {
    KIND_MAGIC   = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_CONTENT = 3'd3,
    KIND_HASH    = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e               byte_kind;
    logic [ByteW-1:0]    data_out;
    logic [ModeW-1:0]    file_mode;
    logic [NameLenW-1:0] name_length;
    logic [BodyLenW-1:0] body_length;
    logic                header_valid;
    logic                record_end;
    logic                hash_ok;
    logic                magic_error;
    logic [ByteW-1:0]    computed_hash;
  } result_t;

  localparam logic [ByteW-1:0] PearsonTab [256] = '{
    8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
    8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
    8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
    8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
    8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
    8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
    8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
    8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
    8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
    8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
    8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
    8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
    8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
    8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
    8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
    8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
    8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
    8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
    8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
    8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
    8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
    8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
    8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
    8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
    8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
    8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
    8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
    8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
    8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
    8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
    8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
    8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
  };

endpackage

[hw/rtl/rdhc_core.sv]
// ----------------------------------------------------------------------------
// rdhc_core
// Record parser state and per-byte decode: phase sequencing, header field
// assembly, section counting and the running Pearson hash.
// ----------------------------------------------------------------------------
module rdhc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [rdhc_pkg::ByteW-1:0]    data_byte_i,
  output rdhc_pkg::result_t             res_o
);
  import rdhc_pkg::*;

  phase_e               phase_q, phase_d;
  logic [HdrIdxW-1:0]   hdr_idx_q, hdr_idx_d;
  logic [BodyLenW-1:0]  remain_q, remain_d;
  logic [ByteW-1:0]     hash_q, hash_d;
  logic [ModeW-1:0]     mode_q, mode_d;
  logic [NameLenW-1:0]  name_len_q, name_len_d;
  logic [BodyLenW-1:0]  body_len_q, body_len_d;
  logic                 magic_err_q, magic_err_d;

  logic [ByteW-1:0]     mix_idx;
  logic [ByteW-1:0]     mixed;
  logic [HdrIdxW-1:0]   hdr_idx_inc;
  logic                 hdr_last;
  logic                 remain_last;
  logic [BodyLenW-1:0]  remain_dec;

  // hash restarts from zero on the magic byte
  assign mix_idx     = ((phase_q == PH_MAGIC) ? '0 : hash_q) ^ data_byte_i;
  assign mixed       = PearsonTab[mix_idx];
  assign hdr_idx_inc = hdr_idx_q + HdrIdxW'(1);
  assign hdr_last    = (hdr_idx_inc >= HeaderBytes);
  assign remain_dec  = remain_q - BodyLenW'(1);
  assign remain_last = (remain_q == BodyLenW'(1));

  // next state
  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    remain_d    = remain_q;
    hash_d      = hash_q;
    mode_d      = mode_q;
    name_len_d  = name_len_q;
    body_len_d  = body_len_q;
    magic_err_d = magic_err_q;
    unique case (phase_q)
      PH_MAGIC: begin
        if (data_byte_i == MagicValue) begin
          hash_d     = mixed;
          mode_d     = '0;
          name_len_d = '0;
          body_len_d = '0;
          hdr_idx_d  = '0;
          phase_d    = PH_HEADER;
        end else begin
          magic_err_d = 1'b1;
          phase_d     = PH_ERROR;
        end
      end
      PH_HEADER: begin
        hash_d = mixed;
        if (hdr_idx_q < ModeEnd) begin
          mode_d = {mode_q[ModeW-ByteW-1:0], data_byte_i};
        end else if (hdr_idx_q < NameLenEnd) begin
          name_len_d = {name_len_q[NameLenW-ByteW-1:0], data_byte_i};
        end else begin
          body_len_d = {body_len_q[BodyLenW-ByteW-1:0], data_byte_i};
        end
        hdr_idx_d = hdr_idx_inc;
        if (hdr_last) begin
          hdr_idx_d = '0;
          if (name_len_d != '0) begin
            phase_d  = PH_NAME;
            remain_d = BodyLenW'(name_len_d);
          end else if (body_len_d != '0) begin
            phase_d  = PH_CONTENT;
            remain_d = body_len_d;
          end else begin
            phase_d  = PH_HASH;
            remain_d = '0;
          end
        end
      end
      PH_NAME: begin
        hash_d   = mixed;
        remain_d = remain_dec;
        if (remain_last) begin
          if (body_len_q != '0) begin
            phase_d  = PH_CONTENT;
            remain_d = body_len_q;
          end else begin
            phase_d  = PH_HASH;
            remain_d = '0;
          end
        end
      end
      PH_CONTENT: begin
        hash_d   = mixed;
        remain_d = remain_dec;
        if (remain_last) begin
          phase_d = PH_HASH;
        end
      end
      PH_HASH: begin
        hash_d  = '0;
        phase_d = PH_MAGIC;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  // per-byte result
  always_comb begin
    res_o               = '0;
    res_o.byte_kind     = KIND_ERROR;
    res_o.data_out      = data_byte_i;
    res_o.file_mode     = mode_d;
    res_o.name_length   = name_len_d;
    res_o.body_length   = body_len_d;
    res_o.magic_error   = magic_err_d;
    res_o.computed_hash = hash_d;
    unique case (phase_q)
      PH_MAGIC: begin
        if (data_byte_i == MagicValue) begin
          res_o.byte_kind = KIND_MAGIC;
        end
      end
      PH_HEADER: begin
        res_o.byte_kind    = KIND_HEADER;
        res_o.header_valid = hdr_last;
      end
      PH_NAME:    res_o.byte_kind = KIND_NAME;
      PH_CONTENT: res_o.byte_kind = KIND_CONTENT;
      PH_HASH: begin
        res_o.byte_kind     = KIND_HASH;
        res_o.record_end    = 1'b1;
        res_o.hash_ok       = (data_byte_i == hash_q);
        res_o.computed_hash = hash_q;
      end
      default: res_o.byte_kind = KIND_ERROR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      hdr_idx_q   <= '0;
      remain_q    <= '0;
      hash_q      <= '0;
      mode_q      <= '0;
      name_len_q  <= '0;
      body_len_q  <= '0;
      magic_err_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      remain_q    <= remain_d;
      hash_q      <= hash_d;
      mode_q      <= mode_d;
      name_len_q  <= name_len_d;
      body_len_q  <= body_len_d;
      magic_err_q <= magic_err_d;
    end
  end

  // error state is only reached through a bad magic byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR) |-> magic_err_q)
    else $error("rdhc_core: error phase without magic error flag");

  // header index stays inside the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q < HeaderBytes)
    else $error("rdhc_core: header index out of range");

  // sections are entered with a non-zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME || phase_q == PH_CONTENT) |-> (remain_q != '0))
    else $error("rdhc_core: empty section counter in name or content phase");

endmodule

[hw/rtl/record_deframer_hash_check.sv]
// ----------------------------------------------------------------------------
// record_deframer_hash_check
// Archive record deframer: tags each byte with its role, decodes the record
// header and checks the trailing Pearson hash byte.
// ----------------------------------------------------------------------------
// usage
//   input channel : one archive byte per transfer on data_byte_i, with
//                   in_valid_i / in_ready_o
//   output channel: exactly one result per input byte, with out_valid_o /
//                   out_ready_i; results leave in input order
//   timing        : a result is presented in the cycle after its byte transfers
//   throughput    : one byte per cycle while results are taken; the whole decode
//                   (phase step, header shift, 48-bit section count and one table
//                   lookup) sits between the parser state and the result register
//   stalls        : while a result waits, a new byte is still taken if the
//                   receiver takes the waiting result in the same cycle;
//                   otherwise in_ready_o drops until the result is taken
//   reset         : rst_ni clears the parser to expect a magic byte, zeroes the
//                   decoded fields and the hash, and clears the sticky magic
//                   error; the result register comes up empty
//   errors        : a wrong magic byte sets magic_error_o, which stays set
//                   until reset; every later byte is tagged as error state
// ----------------------------------------------------------------------------
module record_deframer_hash_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rdhc_pkg::ByteW-1:0]      data_byte_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      byte_kind_o,
  output logic [rdhc_pkg::ByteW-1:0]      data_out_o,
  output logic [rdhc_pkg::ModeW-1:0]      file_mode_o,
  output logic [rdhc_pkg::NameLenW-1:0]   name_length_o,
  output logic [rdhc_pkg::BodyLenW-1:0]   body_length_o,
  output logic                            header_valid_o,
  output logic                            record_end_o,
  output logic                            hash_ok_o,
  output logic                            magic_error_o,
  output logic [rdhc_pkg::ByteW-1:0]      computed_hash_o
);
  import rdhc_pkg::*;

  logic    in_xfer;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  // result register is free when empty or being taken this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // parser state advances only on an input transfer
  rdhc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .data_byte_i (data_byte_i),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_kind_o     = res_q.byte_kind;
  assign data_out_o      = res_q.data_out;
  assign file_mode_o     = res_q.file_mode;
  assign name_length_o   = res_q.name_length;
  assign body_length_o   = res_q.body_length;
  assign header_valid_o  = res_q.header_valid;
  assign record_end_o    = res_q.record_end;
  assign hash_ok_o       = res_q.hash_ok;
  assign magic_error_o   = res_q.magic_error;
  assign computed_hash_o = res_q.computed_hash;

  // every accepted byte leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("record_deframer_hash_check: byte transferred without result");

  // record end flags exactly the hash byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (record_end_o == (byte_kind_o == KIND_HASH)))
    else $error("record_deframer_hash_check: record end and byte kind disagree");

  // hash verdict only on a record end, header completion only on a header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hash_ok_o || header_valid_o) |->
      (hash_ok_o ? record_end_o : (byte_kind_o == KIND_HEADER)))
    else $error("record_deframer_hash_check: status flag on wrong byte");

  // magic error never clears without reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && magic_error_o |=> magic_error_o)
    else $error("record_deframer_hash_check: magic error flag cleared");

  // error kind goes with the sticky flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_kind_o == KIND_ERROR) |-> magic_error_o)
    else $error("record_deframer_hash_check: error tag without magic error");

endmodule
